### rtl/core/mask_nonzero_bounding_box_defines.svh
// Assertion macros used by the bounding box checker
`ifndef MASK_NONZERO_BOUNDING_BOX_DEFINES_SVH
`define MASK_NONZERO_BOUNDING_BOX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MNBB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MNBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mnbb_pkg.sv
// Shared types and constants of the mask bounding box block
package mnbb_pkg;

	localparam int DIM_W       = 13;
	localparam int PIX_W       = 64;
	localparam int PB_W        = 4;
	localparam int MAX_DIM_DEF = 4096;
	localparam int ADDR_W      = 4;
	localparam int APB_DW      = 32;
	localparam int TDATA_OUT_W = 56;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_PIXEL_BYTES  = 2'd2;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd4096;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd4096;
	localparam logic [PB_W-1:0]  PIXEL_BYTES_RST  = 4'd1;

	typedef struct packed {
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
		logic [PB_W-1:0]  pixel_bytes;
	} cfg_t;

	typedef struct packed {
		logic             found;
		logic [DIM_W-1:0] bottom;
		logic [DIM_W-1:0] right;
		logic [DIM_W-1:0] top;
		logic [DIM_W-1:0] left;
	} box_t;

endpackage

### rtl/core/mask_nonzero_bounding_box.sv
// Top level: bounding box of the nonzero pixels of a raster mask frame
// Throughput: one pixel transfer per cycle, sustained, while the result side keeps up.
// Path: the last pixel of a frame passes the input register, then the box is loaded
//   into the result register, which drives the master side once that register is free.
// Reset: arst_n clears counters, box and valid flags at once; the registers return
//   to width 4096, height 4096, one byte per pixel. No clearing pass is needed.
module mask_nonzero_bounding_box
	import mnbb_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// pixel stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [PIX_W-1:0]       s_tdata,   // [63:0] pixel
	// box stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,   // [12:0] left, [25:13] top, [38:26] right,
	                                          // [51:39] bottom, [55:52] zero
	output logic                   m_tuser,   // [0] found
	// configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	cfg_t             cfg_q;
	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic             emit, advance, out_free;
	box_t             box;
	logic [DIM_W*4-1:0] box_data_q;
	logic             found_q;
	logic             m_tvalid_q;

	// Configuration registers: written on the access phase, read back directly
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= FRAME_WIDTH_RST;
			cfg_q.frame_height <= FRAME_HEIGHT_RST;
			cfg_q.pixel_bytes  <= PIXEL_BYTES_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[DIM_W-1:0];
				REG_PIXEL_BYTES:  cfg_q.pixel_bytes  <= pwdata[PB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FRAME_WIDTH:  prdata = APB_DW'(cfg_q.frame_width);
			REG_FRAME_HEIGHT: prdata = APB_DW'(cfg_q.frame_height);
			REG_PIXEL_BYTES:  prdata = APB_DW'(cfg_q.pixel_bytes);
			default:          prdata = '0;
		endcase
	end

	// The result register frees up when empty or when its transfer completes.
	// A pixel that ends no frame never waits for it; the last pixel of a frame
	// holds in stage 1 until the box can be loaded.
	assign out_free = !m_tvalid_q || m_tready;
	assign advance  = valid_s1 && (!emit || out_free);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pixel_s1 <= s_tdata;
		end
	end

	mnbb_track #(
		.MAX_DIM (MAX_DIM)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.advance (advance),
		.pixel   (pixel_s1),
		.emit    (emit),
		.box     (box)
	);

	// Result register: load the finished box, drop valid once it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			box_data_q <= {box.bottom, box.right, box.top, box.left};
			found_q    <= box.found;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_OUT_W'(box_data_q);
	assign m_tuser  = found_q;

endmodule

### rtl/core/mnbb_track.sv
// Raster position counters and running bounding box of set pixels
module mnbb_track
	import mnbb_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             advance,
	input  logic [PIX_W-1:0] pixel,
	output logic             emit,
	output box_t             box
);

	localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int XW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
	localparam logic [XW-1:0] MAX_X = XW'(MAX_DIM);
	localparam logic [CW-1:0] MIN_RST = CW'(MAX_DIM - 1);
	localparam int NBYTES = PIX_W / 8;

	logic [CW-1:0] col_q, row_q, min_col_q, min_row_q, max_col_q, max_row_q;
	logic          any_q;

	logic [XW-1:0] w_eff, h_eff, col_x, row_x, r_x, b_x;
	logic [PB_W-1:0] nb;
	logic [NBYTES-1:0] byte_nz, byte_en;
	logic          set, col_end, row_end;
	logic [CW-1:0] min_col_n, min_row_n, max_col_n, max_row_n;
	logic          any_n;

	always_comb begin
		w_eff = XW'(cfg.frame_width);
		if (w_eff == '0) w_eff = XW'(1);
		else if (w_eff > MAX_X) w_eff = MAX_X;
		h_eff = XW'(cfg.frame_height);
		if (h_eff == '0) h_eff = XW'(1);
		else if (h_eff > MAX_X) h_eff = MAX_X;

		nb = cfg.pixel_bytes;
		if (nb == '0) nb = PB_W'(1);
		else if (nb > PB_W'(NBYTES)) nb = PB_W'(NBYTES);
		for (int i = 0; i < NBYTES; i++) begin
			byte_nz[i] = |pixel[8*i +: 8];
			byte_en[i] = (PB_W'(i) < nb);
		end
		set = |(byte_nz & byte_en);

		col_x = XW'(col_q);
		row_x = XW'(row_q);
		col_end = !(col_x < w_eff - XW'(1));
		row_end = !(row_x < h_eff - XW'(1));
		emit = col_end && row_end;

		min_col_n = (set && col_q < min_col_q) ? col_q : min_col_q;
		max_col_n = (set && col_q > max_col_q) ? col_q : max_col_q;
		min_row_n = (set && row_q < min_row_q) ? row_q : min_row_q;
		max_row_n = (set && row_q > max_row_q) ? row_q : max_row_q;
		any_n = any_q || set;

		// clamp the exclusive edges to a frame that may have shrunk
		r_x = XW'(max_col_n) + XW'(1);
		b_x = XW'(max_row_n) + XW'(1);
		if (r_x > w_eff) r_x = w_eff;
		if (b_x > h_eff) b_x = h_eff;

		if (any_n) begin
			box.left   = DIM_W'(XW'(min_col_n));
			box.top    = DIM_W'(XW'(min_row_n));
			box.right  = r_x[DIM_W-1:0];
			box.bottom = b_x[DIM_W-1:0];
			box.found  = 1'b1;
		end else begin
			box.left   = '0;
			box.top    = '0;
			box.right  = w_eff[DIM_W-1:0];
			box.bottom = h_eff[DIM_W-1:0];
			box.found  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= MIN_RST;
			min_row_q <= MIN_RST;
			max_col_q <= '0;
			max_row_q <= '0;
			any_q     <= 1'b0;
		end else if (advance) begin
			if (emit) begin
				col_q     <= '0;
				row_q     <= '0;
				min_col_q <= MIN_RST;
				min_row_q <= MIN_RST;
				max_col_q <= '0;
				max_row_q <= '0;
				any_q     <= 1'b0;
			end else begin
				col_q     <= col_end ? '0 : col_q + CW'(1);
				row_q     <= col_end ? row_q + CW'(1) : row_q;
				min_col_q <= min_col_n;
				min_row_q <= min_row_n;
				max_col_q <= max_col_n;
				max_row_q <= max_row_n;
				any_q     <= any_n;
			end
		end
	end

endmodule

### rtl/core/mnbb_checker.sv
// Port-level checks on the box stream of the bounding box block
`include "mask_nonzero_bounding_box_defines.svh"

module mnbb_checker
	import mnbb_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [TDATA_OUT_W-1:0] m_tdata,
	input logic                   m_tuser
);

	`MNBB_ASSERT_NEXT(a_valid_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "box dropped while stalled")
	`MNBB_ASSERT_NEXT(a_data_holds, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "box changed while stalled")
	`MNBB_ASSERT_NOW(a_empty_origin, clk, arst_n, m_tvalid && !m_tuser, m_tdata[25:0] == 26'd0, "empty mask gives nonzero origin")
	`MNBB_ASSERT_NOW(a_edges_nonzero, clk, arst_n, m_tvalid, m_tdata[38:26] != 13'd0 && m_tdata[51:39] != 13'd0, "box edge at zero")
	`MNBB_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[55:52] == 4'd0, "padding bits set")

endmodule

bind mask_nonzero_bounding_box mnbb_checker u_mnbb_checker (.*);

### dv/mnbb_box_check.sv
// Box stream checker: tracks the register writes, predicts each frame's box and compares
module mnbb_box_check
	import mnbb_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [PIX_W-1:0]       s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [TDATA_OUT_W-1:0] m_tdata,
	input  logic                   m_tuser,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	input  logic                   pready,
	output int                     mismatches,
	output int                     boxes_due
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t regs;
	int   col_pos;
	int   row_pos;
	int   lo_col;
	int   lo_row;
	int   hi_col;
	int   hi_row;
	bit   seen_set;
	box_t boxes_q[$];

	// zero counts as one, anything past the largest frame as the largest frame
	function automatic int clamp_dim(logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	function automatic logic [PIX_W-1:0] tested_mask(logic [PB_W-1:0] nb);
		int n;
		n = (nb == '0) ? 1 : (nb > 8) ? 8 : int'(nb);
		return (n == 8) ? '1 : (64'd1 << (8 * n)) - 64'd1;
	endfunction

	task automatic restart_frame();
		col_pos  = 0;
		row_pos  = 0;
		lo_col   = MAX_DIM - 1;
		lo_row   = MAX_DIM - 1;
		hi_col   = 0;
		hi_row   = 0;
		seen_set = 1'b0;
	endtask

	task automatic trace_pixel(logic [PIX_W-1:0] px);
		int   w;
		int   h;
		int   r;
		int   b;
		box_t box;
		w = clamp_dim(regs.frame_width);
		h = clamp_dim(regs.frame_height);
		if ((px & tested_mask(regs.pixel_bytes)) != '0) begin
			if (col_pos < lo_col) lo_col = col_pos;
			if (col_pos > hi_col) hi_col = col_pos;
			if (row_pos < lo_row) lo_row = row_pos;
			if (row_pos > hi_row) hi_row = row_pos;
			seen_set = 1'b1;
		end
		// counts left past a shrunken frame end the row or the frame at once
		if (col_pos < w - 1) begin
			col_pos++;
			return;
		end
		col_pos = 0;
		if (row_pos < h - 1) begin
			row_pos++;
			return;
		end
		if (seen_set) begin
			r = (hi_col + 1 > w) ? w : hi_col + 1;
			b = (hi_row + 1 > h) ? h : hi_row + 1;
			box.left   = DIM_W'(lo_col);
			box.top    = DIM_W'(lo_row);
			box.right  = DIM_W'(r);
			box.bottom = DIM_W'(b);
			box.found  = 1'b1;
		end else begin
			box.left   = '0;
			box.top    = '0;
			box.right  = DIM_W'(w);
			box.bottom = DIM_W'(h);
			box.found  = 1'b0;
		end
		boxes_q.push_back(box);
		restart_frame();
	endtask

	task automatic log_fault(string msg);
		if (mismatches < 10)
			$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		box_t got;
		box_t want;
		if (!arst_n) begin
			regs = '{frame_width: FRAME_WIDTH_RST, frame_height: FRAME_HEIGHT_RST,
				pixel_bytes: PIXEL_BYTES_RST};
			restart_frame();
			boxes_q.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_FRAME_WIDTH:  regs.frame_width  = pwdata[DIM_W-1:0];
					REG_FRAME_HEIGHT: regs.frame_height = pwdata[DIM_W-1:0];
					REG_PIXEL_BYTES:  regs.pixel_bytes  = pwdata[PB_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				trace_pixel(s_tdata);
			if (m_tvalid && m_tready) begin
				got = box_t'({m_tuser, m_tdata[4*DIM_W-1:0]});
				if (boxes_q.size() == 0) begin
					log_fault($sformatf("unexpected box l=%0d t=%0d r=%0d b=%0d found=%0b",
						got.left, got.top, got.right, got.bottom, got.found));
				end else begin
					want = boxes_q.pop_front();
					if (got !== want || m_tdata[TDATA_OUT_W-1:4*DIM_W] !== '0)
						log_fault($sformatf({"box mismatch: expected l=%0d t=%0d r=%0d b=%0d ",
							"found=%0b, got l=%0d t=%0d r=%0d b=%0d found=%0b pad=%0h"},
							want.left, want.top, want.right, want.bottom, want.found,
							got.left, got.top, got.right, got.bottom, got.found,
							m_tdata[TDATA_OUT_W-1:4*DIM_W]));
				end
			end
		end
		boxes_due = boxes_q.size();
	end

endmodule

### dv/mask_nonzero_bounding_box_tb.sv
// Testbench top: pixel stimulus, box back-pressure, register writes and the verdict
module mask_nonzero_bounding_box_tb
	import mnbb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Worst run: about 6.5k pixel transfers, each behind the longest idle gap and the
	// longest result stall, stays far below the limit; the limit leaves ample room.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SMALL_ITEMS = 1800;
	// margin for the input and result registers: let an in-flight pixel land before a write
	localparam int SETTLE      = 4;
	// unmapped register slot, written only as noise
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [PIX_W-1:0]       s_tdata;      // [63:0] pixel
	logic                   m_tvalid;
	logic                   m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;      // [12:0] left, [25:13] top, [38:26] right,
	                                      // [51:39] bottom, [55:52] zero
	logic                   m_tuser;      // [0] found
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_W-1:0]      paddr;
	logic [APB_DW-1:0]      pwdata;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;

	int mismatches;
	int boxes_due;
	int cycles;
	bit steady_tail;   // final stretch: no gaps, no stalls
	bit bursty;        // per phase: allow idle bursts at all

	mask_nonzero_bounding_box #(
		.MAX_DIM (MAX_DIM_DEF)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	mnbb_box_check #(
		.MAX_DIM (MAX_DIM_DEF)
	) u_box_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.boxes_due  (boxes_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: give up if the run hangs anywhere
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("mask_nonzero_bounding_box_tb failed");
			$finish;
		end
	end

	// Result side: hold tready low in short random bursts, never in the final stretch
	initial begin : drain
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!steady_tail && bursty && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	// One APB write: setup cycle, access cycle, then drop the select.
	// Bits above the field carry noise that the register must ignore.
	task automatic write_reg(logic [1:0] idx, int val, int field_w);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = ($urandom << field_w) | APB_DW'(val);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Offer one pixel, perhaps after an idle burst, and hold it until the transfer
	task automatic send_pixel(logic [PIX_W-1:0] px);
		int gap;
		gap = (bursty && !steady_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			s_tdata  = {$urandom, $urandom};
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = px;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid, wait for every outstanding box, then let the pipeline drain
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (boxes_due != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Pixel with noise in the ignored bytes; set with the given percentage,
	// in which case exactly one tested byte carries a nonzero value
	function automatic logic [PIX_W-1:0] make_pixel(int density, int nb);
		logic [PIX_W-1:0] px;
		px = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
		for (int i = 0; i < nb; i++)
			px[8*i +: 8] = 8'h00;
		if ($urandom_range(1, 100) <= density)
			px[8*$urandom_range(0, nb - 1) +: 8] = 8'($urandom_range(1, 255));
		return px;
	endfunction

	task automatic run_pixels(int count, int density, int nb);
		for (int i = 0; i < count; i++)
			send_pixel(make_pixel(density, nb));
	endtask

	initial begin : stimulus
		int cur_w;
		int cur_h;
		int cur_pb;
		int nb;
		int fed;
		int frame_px;
		int count;
		int density;
		bit first;

		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		steady_tail = 1'b0;
		bursty      = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset geometry (4096 x 4096, one tested byte): start a row, then shrink
		// the frame under it. The box lies beyond the new width and is clamped.
		send_pixel(64'h0000_0000_0000_0100);   // only byte 1: ignored
		send_pixel(64'h0000_0000_0000_0000);
		send_pixel(64'h0000_0000_0000_0001);   // set at column 2
		settle();
		write_reg(REG_FRAME_WIDTH, 2, DIM_W);
		write_reg(REG_FRAME_HEIGHT, 1, DIM_W);
		send_pixel(64'h0);                     // column count past the end: frame ends

		// Zero sizes and zero byte count all act as one
		settle();
		write_reg(REG_FRAME_WIDTH, 0, DIM_W);
		write_reg(REG_FRAME_HEIGHT, 0, DIM_W);
		write_reg(REG_PIXEL_BYTES, 0, PB_W);
		send_pixel(64'h0000_0000_0000_0001);
		send_pixel(64'hFFFF_FFFF_FFFF_FF00);   // empty: only the low byte counts
		send_pixel(64'h0);

		// All eight bytes tested: top bit alone marks a pixel
		settle();
		write_reg(REG_FRAME_WIDTH, 3, DIM_W);
		write_reg(REG_FRAME_HEIGHT, 2, DIM_W);
		write_reg(REG_PIXEL_BYTES, 8, PB_W);
		for (int i = 0; i < 6; i++)
			send_pixel(i == 4 ? 64'h8000_0000_0000_0000 : 64'h0);

		// Byte count above eight acts as eight
		settle();
		write_reg(REG_FRAME_WIDTH, 2, DIM_W);
		write_reg(REG_FRAME_HEIGHT, 1, DIM_W);
		write_reg(REG_PIXEL_BYTES, 15, PB_W);
		send_pixel(64'h0);
		send_pixel(64'h0100_0000_0000_0000);

		// Four tested bytes: the upper half is ignored
		settle();
		write_reg(REG_FRAME_HEIGHT, 2, DIM_W);
		write_reg(REG_PIXEL_BYTES, 4, PB_W);
		send_pixel(64'hFFFF_FFFF_0000_0000);
		send_pixel(64'h0000_0000_FF00_0000);
		send_pixel(64'h0);
		send_pixel(64'h0);

		// Widest row: a width beyond the largest frame acts as the largest.
		// Mark the last column so that right reaches its top value.
		settle();
		write_reg(REG_FRAME_HEIGHT, 1, DIM_W);
		write_reg(REG_FRAME_WIDTH, 8191, DIM_W);
		write_reg(REG_PIXEL_BYTES, 1, PB_W);
		for (int i = 0; i < MAX_DIM_DEF; i++)
			send_pixel(i == MAX_DIM_DEF - 1 ? 64'h1 : make_pixel(1, 1));

		// Tallest column, left unfinished: the next phase shrinks it mid frame
		settle();
		write_reg(REG_FRAME_WIDTH, 1, DIM_W);
		write_reg(REG_FRAME_HEIGHT, 8191, DIM_W);
		run_pixels(300, 2, 1);

		// Random phases: small frames, random densities, and leftover partial
		// frames so that later writes often land mid frame
		fed   = 0;
		first = 1'b1;
		while (fed < SMALL_ITEMS) begin
			settle();
			if (fed >= SMALL_ITEMS * 4 / 5)
				steady_tail = 1'b1;
			bursty = ($urandom_range(0, 3) != 0);
			if (first || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0:       cur_w = 0;
					1:       cur_w = 1;
					default: cur_w = $urandom_range(2, 16);
				endcase
				write_reg(REG_FRAME_WIDTH, cur_w, DIM_W);
			end
			if (first || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0:       cur_h = 0;
					1:       cur_h = 1;
					default: cur_h = $urandom_range(2, 8);
				endcase
				write_reg(REG_FRAME_HEIGHT, cur_h, DIM_W);
			end
			if (first || $urandom_range(0, 3) != 0) begin
				cur_pb = $urandom_range(0, 15);
				write_reg(REG_PIXEL_BYTES, cur_pb, PB_W);
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_SPARE, $urandom_range(0, 8191), DIM_W);
			first = 1'b0;

			nb       = (cur_pb == 0) ? 1 : (cur_pb > 8) ? 8 : cur_pb;
			frame_px = (cur_w == 0 ? 1 : cur_w) * (cur_h == 0 ? 1 : cur_h);
			count    = frame_px * $urandom_range(1, 3);
			if ($urandom_range(0, 2) == 0)
				count += $urandom_range(1, frame_px);
			case ($urandom_range(0, 4))
				0:       density = 0;
				1:       density = 3;
				2:       density = 15;
				3:       density = 50;
				default: density = 100;
			endcase
			run_pixels(count, density, nb);
			fed += count;
		end

		// Drain every box, then allow for the pipeline
		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && boxes_due == 0)
			$display("mask_nonzero_bounding_box_tb passed");
		else
			$display("mask_nonzero_bounding_box_tb failed");
		$finish;
	end

endmodule
